### hw/rtl/vpd_pkg.sv
// shared types, constants and helper functions of the vapor pressure deficit block
package vpd_pkg;

   // field widths
   localparam int TempW  = 16;
   localparam int RhW    = 16;
   localparam int CompW  = 14;   // 10000 - rh, 0..10000
   localparam int DefW   = 18;

   // temperature ratio divider
   localparam int DenW      = 23;   // 100 * (t + 23730)
   localparam int MagW      = 26;   // |1727 * t|
   localparam int NumW      = 58;   // (mag << 32) + den / 2
   localparam int QuoW      = 38;   // quotient bits kept, more means a very cold reading
   localparam int DivStages = QuoW / 2;

   // range reduction and series
   localparam int KW        = 6;
   localparam int XsW       = 38;
   localparam int NumTerms  = 12;   // series terms two to thirteen
   localparam int SumW      = 33;
   localparam int MantW     = 46;
   localparam int EsW       = 44;
   localparam int ProdW     = 58;

   localparam logic signed [16:0] TempOffset = 17'sd23730;
   localparam logic [10:0]        RatioMul   = 11'd1727;
   localparam logic [6:0]         DenMul     = 7'd100;
   localparam logic signed [16:0] RhFull     = 17'sd10000;

   localparam logic [31:0]    Ln2Q32   = 32'd2977044472;
   localparam logic [XsW-1:0] KBias    = 38'd139921090184;  // 47 * ln2 in Q32
   localparam logic [QuoW-1:0] XColdLim = 38'h20_0000_0000;  // 32.0 in Q32
   localparam logic [6:0]     ShiftBase = 7'd77;            // 47 + 16 + 14
   localparam logic [12:0]    Es0Units  = 13'd6108;

   // floor(2^34 / n) for n = 2 .. 13
   localparam logic [33:0] TermRecip [NumTerms] = '{
      34'd8589934592, 34'd5726623061, 34'd4294967296, 34'd3435973836,
      34'd2863311530, 34'd2454267026, 34'd2147483648, 34'd1908874353,
      34'd1717986918, 34'd1561806289, 34'd1431655765, 34'd1321528398
   };

   // final scaling
   localparam logic [58:0] RoundAdd  = 59'd327680000;    // 5000 * 65536
   localparam logic [42:0] SatLim    = 43'd2621440000;   // 262144 * 10000
   localparam logic [31:0] Recip10k  = 32'd3518437208;   // floor(2^45 / 10000)
   localparam logic [31:0] TenK      = 32'd10000;

   // register indexes on the control port
   localparam logic RegTempLow  = 1'b0;
   localparam logic RegTempHigh = 1'b1;

   typedef struct packed {
      logic              ok;
      logic              neg;
      logic [NumW-1:0]   num;
      logic [DenW-1:0]   den;
      logic [CompW-1:0]  rh_comp;
   } front_type;

   typedef struct packed {
      logic              ok;
      logic              neg;
      logic              ovf;
      logic [DenW-1:0]   rem;
      logic [QuoW-1:0]   quo;
      logic [QuoW-1:0]   low;
      logic [DenW-1:0]   den;
      logic [CompW-1:0]  rh_comp;
   } div_stage_type;

   typedef struct packed {
      logic              ok;
      logic              neg;
      logic              ovf;
      logic [QuoW-1:0]   quo;
      logic [CompW-1:0]  rh_comp;
   } div_type;

   typedef struct packed {
      logic              ok;
      logic              zero;
      logic [KW-1:0]     kk;
      logic [XsW-1:0]    rem;
      logic [CompW-1:0]  rh_comp;
   } kred_type;

   typedef struct packed {
      logic              ok;
      logic              zero;
      logic [KW-1:0]     kk;
      logic [31:0]       r;
      logic [31:0]       term;
      logic [31:0]       quot;
      logic [SumW-1:0]   sum;
      logic [CompW-1:0]  rh_comp;
   } term_type;

   typedef struct packed {
      logic              ok;
      logic              zero;
      logic [KW-1:0]     kk;
      logic [SumW-1:0]   sum;
      logic [CompW-1:0]  rh_comp;
   } exp_type;

   // one restoring division step, returns {quotient bit, remainder}
   function automatic logic [DenW:0] div_step(input logic [DenW-1:0] rem,
                                              input logic nb,
                                              input logic [DenW-1:0] den);
      logic [DenW:0] t;
      t = {rem, nb};
      if (t >= {1'b0, den}) begin
         return {1'b1, DenW'(t - {1'b0, den})};
      end
      return {1'b0, t[DenW-1:0]};
   endfunction

   // one step of the division by ln2, returns {quotient bit, remainder}
   function automatic logic [XsW:0] k_step(input logic [XsW-1:0] rem,
                                           input logic [2:0] sh);
      logic [XsW-1:0] d;
      d = XsW'(Ln2Q32) << sh;
      if (rem >= d) begin
         return {1'b1, rem - d};
      end
      return {1'b0, rem};
   endfunction

endpackage

### hw/rtl/vpd_front.sv
// input stage: range checks and numerator and denominator of the exponent ratio
module vpd_front
   import vpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic signed [TempW-1:0] air_temp,
   input  logic                    temp_present,
   input  logic signed [RhW-1:0]   rel_humidity,
   input  logic                    humidity_present,
   input  logic signed [TempW-1:0] temp_low,
   input  logic signed [TempW-1:0] temp_high,
   output logic                    out_valid,
   output front_type               out_data
);

   logic      valid_ff;
   front_type data_ff;
   front_type data_in;

   logic signed [16:0] t_off;
   logic [15:0]        t_abs;
   logic [MagW-1:0]    mag;
   logic [DenW-1:0]    den;
   logic signed [16:0] rh_diff;

   // checks, |1727*t|, 100*(t+23730)
   always_comb begin
      t_off   = 17'(air_temp) + TempOffset;
      t_abs   = air_temp[TempW-1] ? 16'(-air_temp) : 16'(air_temp);
      mag     = MagW'({10'b0, t_abs} * MagW'(RatioMul));
      den     = DenW'(DenW'(t_off[15:0]) * DenW'(DenMul));
      rh_diff = RhFull - 17'(rel_humidity);

      data_in.ok = temp_present && humidity_present
                   && (air_temp >= temp_low) && (air_temp <= temp_high)
                   && (rel_humidity >= 16'sd0) && (rel_humidity <= 16'sd10000)
                   && (t_off > 17'sd0);
      data_in.neg     = air_temp[TempW-1];
      // low 32 bits of mag<<32 are zero, so adding den/2 is a concatenation
      data_in.num     = {mag, 10'b0, den[DenW-1:1]};
      data_in.den     = den;
      data_in.rh_comp = rh_diff[CompW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/vpd_div.sv
// pipelined restoring divider for the exponent ratio, two quotient bits per stage
module vpd_div
   import vpd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output div_type   out_data
);

   logic [DivStages-1:0] vld_ff;
   logic [DivStages-1:0] vld_in;
   div_stage_type        st_ff  [DivStages];
   div_stage_type        st_in  [DivStages];
   div_stage_type        st_src [DivStages];
   div_stage_type        first;

   // top quotient bits beyond the kept ones show up as overflow
   always_comb begin
      first.ok      = in_data.ok;
      first.neg     = in_data.neg;
      first.rem     = DenW'(in_data.num[NumW-1:QuoW]);
      first.ovf     = DenW'(in_data.num[NumW-1:QuoW]) >= in_data.den;
      first.quo     = '0;
      first.low     = in_data.num[QuoW-1:0];
      first.den     = in_data.den;
      first.rh_comp = in_data.rh_comp;
   end

   assign vld_in = {vld_ff[DivStages-2:0], in_valid};

   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      logic [DenW:0] r1;
      logic [DenW:0] r2;

      if (s == 0) begin : g_head
         assign st_src[s] = first;
      end else begin : g_body
         assign st_src[s] = st_ff[s-1];
      end

      // two restoring steps
      always_comb begin
         r1 = div_step(st_src[s].rem, st_src[s].low[QuoW-1], st_src[s].den);
         r2 = div_step(r1[DenW-1:0], st_src[s].low[QuoW-2], st_src[s].den);
         st_in[s]     = st_src[s];
         st_in[s].rem = r2[DenW-1:0];
         st_in[s].quo = {st_src[s].quo[QuoW-3:0], r1[DenW], r2[DenW]};
         st_in[s].low = {st_src[s].low[QuoW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_in[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_comb begin
      out_data.ok      = st_ff[DivStages-1].ok;
      out_data.neg     = st_ff[DivStages-1].neg;
      out_data.ovf     = st_ff[DivStages-1].ovf;
      out_data.quo     = st_ff[DivStages-1].quo;
      out_data.rh_comp = st_ff[DivStages-1].rh_comp;
   end

   assign out_valid = vld_ff[DivStages-1];

endmodule

### hw/rtl/vpd_exp.sv
// exponential: reduction by ln2 and a pipelined taylor series, three stages per term
module vpd_exp
   import vpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    out_valid,
   output exp_type out_data
);

   // bias stage
   logic     bv_ff;
   kred_type bs_ff;
   kred_type bs_in;

   always_comb begin
      bs_in.ok      = in_data.ok;
      bs_in.zero    = in_data.neg && (in_data.ovf || (in_data.quo > XColdLim));
      bs_in.kk      = '0;
      bs_in.rem     = in_data.neg ? KBias - in_data.quo : KBias + in_data.quo;
      bs_in.rh_comp = in_data.rh_comp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
      end else if (adv) begin
         bv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bs_ff <= bs_in;
      end
   end

   // division by ln2, two bits of k per stage
   logic [2:0] kv_ff;
   logic [2:0] kv_in;
   kred_type   ks_ff  [3];
   kred_type   ks_in  [3];
   kred_type   ks_src [3];

   assign kv_in = {kv_ff[1:0], bv_ff};

   for (genvar j = 0; j < 3; j++) begin : g_kred
      logic [XsW:0] a1;
      logic [XsW:0] a2;

      if (j == 0) begin : g_head
         assign ks_src[j] = bs_ff;
      end else begin : g_body
         assign ks_src[j] = ks_ff[j-1];
      end

      always_comb begin
         a1 = k_step(ks_src[j].rem, 3'(5 - 2 * j));
         a2 = k_step(a1[XsW-1:0], 3'(4 - 2 * j));
         ks_in[j]     = ks_src[j];
         ks_in[j].rem = a2[XsW-1:0];
         ks_in[j].kk  = {ks_src[j].kk[KW-3:0], a1[XsW], a2[XsW]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            kv_ff[j] <= 1'b0;
         end else if (adv) begin
            kv_ff[j] <= kv_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ks_ff[j] <= ks_in[j];
         end
      end
   end

   // series seed: sum = 1 + r, term = r
   term_type seed;

   always_comb begin
      seed.ok      = ks_ff[2].ok;
      seed.zero    = ks_ff[2].zero;
      seed.kk      = ks_ff[2].kk;
      seed.r       = ks_ff[2].rem[31:0];
      seed.term    = ks_ff[2].rem[31:0];
      seed.quot    = '0;
      seed.sum     = {1'b1, ks_ff[2].rem[31:0]};
      seed.rh_comp = ks_ff[2].rh_comp;
   end

   // series terms, each a multiply, a reciprocal multiply and a correction
   logic [NumTerms-1:0] va_ff;
   logic [NumTerms-1:0] vb_ff;
   logic [NumTerms-1:0] vc_ff;
   logic [NumTerms-1:0] va_in;
   term_type ta_ff [NumTerms];
   term_type tb_ff [NumTerms];
   term_type tc_ff [NumTerms];
   term_type ta_in [NumTerms];
   term_type tb_in [NumTerms];
   term_type tc_in [NumTerms];
   term_type t_src [NumTerms];

   assign va_in = {vc_ff[NumTerms-2:0], kv_ff[2]};

   for (genvar i = 0; i < NumTerms; i++) begin : g_term
      localparam logic [3:0] NDiv = 4'(i + 2);
      logic [63:0] pa;
      logic [65:0] pb;
      logic [35:0] pc;
      logic [31:0] diff;
      logic [31:0] fixq;

      if (i == 0) begin : g_head
         assign t_src[i] = seed;
      end else begin : g_body
         assign t_src[i] = tc_ff[i-1];
      end

      // term * r in Q32
      always_comb begin
         pa = 64'(t_src[i].term) * 64'(t_src[i].r);
         ta_in[i]      = t_src[i];
         ta_in[i].term = pa[63:32];
      end

      // estimate of the quotient by n, at most one low
      always_comb begin
         pb = 66'(ta_ff[i].term) * 66'(TermRecip[i]);
         tb_in[i]      = ta_ff[i];
         tb_in[i].quot = pb[65:34];
      end

      // correct the estimate and accumulate
      always_comb begin
         pc   = 36'(tb_ff[i].quot) * 36'(NDiv);
         diff = tb_ff[i].term - pc[31:0];
         fixq = (diff >= 32'(NDiv)) ? tb_ff[i].quot + 32'd1 : tb_ff[i].quot;
         tc_in[i]      = tb_ff[i];
         tc_in[i].term = fixq;
         tc_in[i].sum  = tb_ff[i].sum + SumW'(fixq);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff[i] <= 1'b0;
            vb_ff[i] <= 1'b0;
            vc_ff[i] <= 1'b0;
         end else if (adv) begin
            va_ff[i] <= va_in[i];
            vb_ff[i] <= va_ff[i];
            vc_ff[i] <= vb_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ta_ff[i] <= ta_in[i];
            tb_ff[i] <= tb_in[i];
            tc_ff[i] <= tc_in[i];
         end
      end
   end

   always_comb begin
      out_data.ok      = tc_ff[NumTerms-1].ok;
      out_data.zero    = tc_ff[NumTerms-1].zero;
      out_data.kk      = tc_ff[NumTerms-1].kk;
      out_data.sum     = tc_ff[NumTerms-1].sum;
      out_data.rh_comp = tc_ff[NumTerms-1].rh_comp;
   end

   assign out_valid = vc_ff[NumTerms-1];

endmodule

### hw/rtl/vpd_out.sv
// scaling to saturation pressure, humidity product, division by 10000 and result register
module vpd_out
   import vpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  exp_type         in_data,
   output logic            out_valid,
   output logic [DefW-1:0] deficit,
   output logic            deficit_valid
);

   logic [5:0] vld_ff;
   logic [5:0] vld_in;

   assign vld_in = {vld_ff[4:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // 6108 * e^r
   logic [MantW-1:0] m_ff;
   logic [MantW-1:0] m_in;
   logic             ok0_ff;
   logic             zero0_ff;
   logic [KW-1:0]    kk0_ff;
   logic [CompW-1:0] rh0_ff;

   assign m_in = MantW'(in_data.sum) * MantW'(Es0Units);

   // shift by k and drop 16 bits
   logic [EsW-1:0]   es_ff;
   logic [EsW-1:0]   es_in;
   logic [59:0]      wide;
   logic [6:0]       amt;
   logic             ok1_ff;
   logic [CompW-1:0] rh1_ff;

   always_comb begin
      wide  = {m_ff, 14'b0};
      amt   = ShiftBase - 7'(kk0_ff);
      es_in = zero0_ff ? '0 : EsW'(wide >> amt);
   end

   // es * (10000 - rh)
   logic [ProdW-1:0] prod_ff;
   logic [ProdW-1:0] prod_in;
   logic             ok2_ff;

   assign prod_in = ProdW'(es_ff) * ProdW'(rh1_ff);

   // round, drop fraction, saturation check
   logic [58:0] rsum;
   logic [31:0] v_ff;
   logic [31:0] v_in;
   logic        sat_ff;
   logic        sat_in;
   logic        ok3_ff;

   always_comb begin
      rsum   = 59'(prod_ff) + RoundAdd;
      sat_in = rsum[58:16] >= SatLim;
      v_in   = rsum[47:16];
   end

   // reciprocal estimate of v / 10000
   logic [63:0] pq;
   logic [18:0] q0_ff;
   logic [18:0] q0_in;
   logic [31:0] v4_ff;
   logic        sat4_ff;
   logic        ok4_ff;

   always_comb begin
      pq    = 64'(v_ff) * 64'(Recip10k);
      q0_in = pq[63:45];
   end

   // correction and result register
   logic [31:0]     pr;
   logic [31:0]     rem;
   logic [18:0]     qfix;
   logic [DefW-1:0] def_ff;
   logic [DefW-1:0] def_in;
   logic            flag_ff;

   always_comb begin
      pr     = 32'(q0_ff) * TenK;
      rem    = v4_ff - pr;
      qfix   = (rem >= TenK) ? q0_ff + 19'd1 : q0_ff;
      def_in = !ok4_ff ? '0 : (sat4_ff ? '1 : qfix[DefW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff     <= m_in;
         ok0_ff   <= in_data.ok;
         zero0_ff <= in_data.zero;
         kk0_ff   <= in_data.kk;
         rh0_ff   <= in_data.rh_comp;

         es_ff    <= es_in;
         ok1_ff   <= ok0_ff;
         rh1_ff   <= rh0_ff;

         prod_ff  <= prod_in;
         ok2_ff   <= ok1_ff;

         v_ff     <= v_in;
         sat_ff   <= sat_in;
         ok3_ff   <= ok2_ff;

         q0_ff    <= q0_in;
         v4_ff    <= v_ff;
         sat4_ff  <= sat_ff;
         ok4_ff   <= ok3_ff;

         def_ff   <= def_in;
         flag_ff  <= ok4_ff;
      end
   end

   assign out_valid     = vld_ff[5];
   assign deficit       = def_ff;
   assign deficit_valid = flag_ff;

endmodule

### hw/rtl/vapor_pressure_deficit_top.sv
// top level: control registers, stream handshake and the vapor pressure deficit pipeline
//
//  group  direction  contents
//  req    in         tdata {rel_humidity, air_temp}, tuser {humidity_present, temp_present}
//  rsp    out        tdata {6'b0, deficit}, tuser {deficit_valid}
//  csr    in/out     temp_low_limit at 0x0, temp_high_limit at 0x4
//
// one beat enters per cycle while the pipeline advances; a result passes through
// 1 input stage, 19 divider stages, 40 exponential stages and 6 output stages
// the whole pipeline holds while a result waits on rsp_tready
// reset empties the pipeline and loads the limits with -50.00 C and 60.00 C
module vapor_pressure_deficit_top
   import vpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] air_temp, [31:16] rel_humidity
   input  logic [1:0]  req_tuser,   // [0] temp_present, [1] humidity_present

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [17:0] deficit, rest zero
   output logic [0:0]  rsp_tuser,   // [0] deficit_valid

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // limit registers
   logic signed [TempW-1:0] low_ff;
   logic signed [TempW-1:0] low_in;
   logic signed [TempW-1:0] high_ff;
   logic signed [TempW-1:0] high_in;
   logic                    csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            RegTempLow:  low_in  = csr_pwdata[TempW-1:0];
            RegTempHigh: high_in = csr_pwdata[TempW-1:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= -16'sd5000;
         high_ff <= 16'sd6000;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   // register read
   always_comb begin
      unique case (csr_paddr[2])
         RegTempLow:  csr_prdata = {{16{low_ff[TempW-1]}}, low_ff};
         RegTempHigh: csr_prdata = {{16{high_ff[TempW-1]}}, high_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // pipeline advance: move unless a result waits
   logic adv;
   logic out_valid;

   assign adv        = !out_valid || rsp_tready;
   assign req_tready = adv;

   logic      f_valid;
   front_type f_data;
   logic      d_valid;
   div_type   d_data;
   logic      e_valid;
   exp_type   e_data;
   logic [DefW-1:0] deficit;
   logic            deficit_valid;

   vpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .in_valid         (req_tvalid),
      .air_temp         (req_tdata[15:0]),
      .temp_present     (req_tuser[0]),
      .rel_humidity     (req_tdata[31:16]),
      .humidity_present (req_tuser[1]),
      .temp_low         (low_ff),
      .temp_high        (high_ff),
      .out_valid        (f_valid),
      .out_data         (f_data)
   );

   vpd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_data  (d_data)
   );

   vpd_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid),
      .in_data   (d_data),
      .out_valid (e_valid),
      .out_data  (e_data)
   );

   vpd_out u_out (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (e_valid),
      .in_data       (e_data),
      .out_valid     (out_valid),
      .deficit       (deficit),
      .deficit_valid (deficit_valid)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {6'b0, deficit};
   assign rsp_tuser  = deficit_valid;

endmodule

### tb/tb_top.sv
// testbench for the vapor pressure deficit block: stream stimulus, predictor and result check
module tb_top;
   import vpd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Ln2 = 64'd2977044472;
   localparam int CycleLimit = 400000;
   localparam int TailCycles = 90;
   localparam logic [2:0] AddrLow  = {RegTempLow, 2'b00};
   localparam logic [2:0] AddrHigh = {RegTempHigh, 2'b00};

   typedef struct packed {
      logic signed [15:0] air_temp;
      logic               temp_present;
      logic signed [15:0] rel_humidity;
      logic               humidity_present;
   } sample_type;

   typedef struct packed {
      logic [17:0] deficit;
      logic        deficit_valid;
   } vpd_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;
   logic [1:0]  req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   vapor_pressure_deficit_top dut (.*);

   sample_type sample_q[$];
   vpd_type    deficit_q[$];
   sample_type drv_s;
   logic signed [15:0] low_limit, high_limit;
   int send_idle = 17, recv_idle = 52;
   int mismatches = 0;
   int cycles = 0;
   bit hold_off = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // saturation pressure in 0.0001 kPa with 16 fraction bits
   function automatic longint unsigned es_q16(int t);
      longint prod, x, k, r, qs;
      longint unsigned den, mag, q, term, sum, m;
      bit neg;
      prod = 1727 * longint'(t);
      den = 100 * (longint'(t) + 23730);
      neg = prod < 0;
      mag = longint'(neg ? -prod : prod);
      mag = mag << 32;
      q = (mag + den / 2) / den;
      qs = q;
      x = neg ? -qs : qs;
      if (x < -64'sd137438953472) return 0;
      k = x / Ln2;
      r = x - k * Ln2;
      if (r < 0) begin
         r += Ln2;
         k--;
      end
      term = 64'd4294967296;
      sum = term;
      for (int n = 1; n <= 13; n++) begin
         term = ((term * longint'(r)) >> 32) / n;
         sum += term;
      end
      m = 6108 * sum;
      if (k >= 0) begin
         if (k > 15) return 64'hFFFF_FFFF_FFFF_FFFF >> 16;
         m = m << k;
      end else begin
         if (k < -63) return 0;
         m = m >> (-k);
      end
      return m >> 16;
   endfunction

   function automatic vpd_type predict_deficit(sample_type s);
      vpd_type o;
      int t, rh;
      longint unsigned es, num, d;
      o = '0;
      t = s.air_temp;
      rh = s.rel_humidity;
      if (!s.temp_present || !s.humidity_present) return o;
      if (t < low_limit || t > high_limit) return o;
      if (rh < 0 || rh > 10000) return o;
      if (t + 23730 <= 0) return o;
      es = es_q16(t);
      if (es > (64'hFFFF_FFFF_FFFF_FFFF >> 16) / 2) es = (64'hFFFF_FFFF_FFFF_FFFF >> 16) / 2;
      num = es * longint'(10000 - rh) + 64'd327680000;
      d = num / 64'd655360000;
      if (d > 262143) d = 262143;
      o.deficit = d[17:0];
      o.deficit_valid = 1;
      return o;
   endfunction

   // driver: the queue head is the beat on the bus until it is taken
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            deficit_q.push_back(predict_deficit(sample_q.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (sample_q.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
               drv_s = sample_q[0];
               req_tvalid <= 1;
               req_tdata <= {drv_s.rel_humidity, drv_s.air_temp};
               req_tuser <= {drv_s.humidity_present, drv_s.temp_present};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
      if (!reset && rsp_tvalid && rsp_tready) begin
         vpd_type got, want;
         got.deficit = rsp_tdata[17:0];
         got.deficit_valid = rsp_tuser[0];
         if (deficit_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = deficit_q.pop_front();
            if (got != want || rsp_tdata[23:18] != 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected deficit %0d valid %0d, got %0d valid %0d",
                           want.deficit, want.deficit_valid, got.deficit, got.deficit_valid);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic signed [15:0] val);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= {{16{val[15]}}, val};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (addr == AddrLow) low_limit = val;
      else if (addr == AddrHigh) high_limit = val;
   endtask

   task automatic drain();
      while (sample_q.size() > 0 || req_tvalid || deficit_q.size() > 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   function automatic sample_type rand_sample();
      sample_type s;
      int sel;
      sel = $urandom_range(99);
      s.temp_present = ($urandom_range(19) != 0);
      s.humidity_present = ($urandom_range(19) != 0);
      if (sel < 70) s.air_temp = 16'($urandom_range(11000) - 5000);
      else if (sel < 80) s.air_temp = 16'($urandom_range(30000) - 24000);
      else s.air_temp = 16'($urandom);
      sel = $urandom_range(99);
      if (sel < 80) s.rel_humidity = 16'($urandom_range(10000));
      else if (sel < 85) s.rel_humidity = (sel & 1) ? 16'sd0 : 16'sd10000;
      else s.rel_humidity = 16'($urandom);
      return s;
   endfunction

   task automatic push(int t, int rh, bit tp = 1, bit hp = 1);
      sample_type s;
      s.air_temp = 16'(t);
      s.rel_humidity = 16'(rh);
      s.temp_present = tp;
      s.humidity_present = hp;
      sample_q.push_back(s);
   endtask

   initial begin
      low_limit = -5000;
      high_limit = 6000;
      repeat (4) @(posedge clock);
      reset <= 0;
      // directed: extremes, missing readings, limit edges, cold and hot
      push(0, 0); push(0, 10000); push(2500, 5000); push(-5000, 3000);
      push(6000, 0); push(-5001, 100); push(6001, 100); push(2000, -1);
      push(2000, 10001); push(2000, 5000, 0, 1); push(2000, 5000, 1, 0);
      push(2000, 5000, 0, 0); push(-32768, 32767); push(32767, -32768);
      push(-1, 1); push(1, 9999);
      drain();
      // wide limits: cold region, below absolute formula limit, saturation
      csr_write(AddrLow, 16'sh8000);
      csr_write(AddrHigh, 16'sh7FFF);
      push(-23730, 0); push(-23729, 0); push(-23000, 0); push(-20000, 0);
      push(32767, 0); push(20000, 0); push(-32768, 0);
      for (int i = 0; i < 300; i++) sample_q.push_back(rand_sample());
      drain();
      // crossed limits reject every temperature
      csr_write(AddrLow, 16'sd1000);
      csr_write(AddrHigh, -16'sd1000);
      push(0, 5000); push(1000, 5000); push(-1000, 5000);
      for (int i = 0; i < 50; i++) sample_q.push_back(rand_sample());
      drain();
      // swapped idling, narrow random limits
      send_idle = 52;
      recv_idle = 17;
      csr_write(AddrLow, 16'($urandom_range(3000) - 4000));
      csr_write(AddrHigh, 16'($urandom_range(5000)));
      for (int i = 0; i < 300; i++) sample_q.push_back(rand_sample());
      // pause the sender until every result has arrived
      wait (sample_q.size() < 150);
      hold_off = 1;
      while (req_tvalid || deficit_q.size() > 0) @(posedge clock);
      hold_off = 0;
      drain();
      // no idling, reset limits back
      send_idle = 0;
      recv_idle = 0;
      csr_write(AddrLow, -16'sd5000);
      csr_write(AddrHigh, 16'sd6000);
      for (int i = 0; i < 280; i++) sample_q.push_back(rand_sample());
      drain();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

### sim.f
hw/rtl/vpd_pkg.sv
hw/rtl/vpd_front.sv
hw/rtl/vpd_div.sv
hw/rtl/vpd_exp.sv
hw/rtl/vpd_out.sv
hw/rtl/vapor_pressure_deficit_top.sv
tb/tb_top.sv
